@@ design/sha1bs_pkg.sv @@
// Shared types and constants for the byte-serial SHA-1 hasher.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1bs_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_ABSORB = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Status codes on the output channel
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Block fill positions
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  // Last round index and last digest word index
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // Round function groups
  localparam logic [1:0] PH_CHOOSE = 2'd0;
  localparam logic [1:0] PH_PAR_LO = 2'd1;
  localparam logic [1:0] PH_MAJ    = 2'd2;
  localparam logic [1:0] PH_PAR_HI = 2'd3;

  // Initial hash words, element 0 is H0
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one per group of twenty rounds
  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  // Source of the byte shifted into the block register
  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      init_hash;
    logic      shift_en;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      load_vars;
    logic      round_en;
    logic [1:0] phase;
    logic      hash_add;
    logic      clear_len;
    logic [2:0] word_sel;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       len_carry;
  } dp_stat_t;

  // Result register load request
  typedef struct packed {
    logic       load;
    logic       status;
    logic       use_digest;
    logic [2:0] index;
    logic       last;
  } res_t;

endpackage

@@ design/sha1bs_dp.sv @@
// Datapath of the SHA-1 hasher: block/schedule shift register, working
// variables, hash words, bit count and fill count. Uses sha1bs_pkg.
module sha1bs_dp import sha1bs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     ctl,
  input  logic [7:0]  data_byte,
  output dp_stat_t    stat,
  output logic [31:0] digest
);

  logic [511:0]     sched;
  logic [4:0][31:0] hash;
  logic [31:0]      va, vb, vc, vd, ve;
  logic [63:0]      bit_len;
  logic [5:0]       fill;

  logic [31:0]     w0, w2, w8, w13, w_mix, w_new;
  logic [31:0]     f_val, t_sum;
  logic [7:0][7:0] len_bytes;
  logic [7:0]      byte_in;

  // Schedule taps: word j of the window sits at bits [511-32j -: 32]
  assign w0    = sched[511:480];
  assign w2    = sched[447:416];
  assign w8    = sched[255:224];
  assign w13   = sched[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Round function by group
  always_comb begin
    case (ctl.phase)
      PH_CHOOSE: f_val = (vb & vc) | (~vb & vd);
      PH_MAJ:    f_val = (vb & vc) | (vb & vd) | (vc & vd);
      default:   f_val = vb ^ vc ^ vd;
    endcase
  end

  assign t_sum = {va[26:0], va[31:27]} + f_val + ve + w0 + ROUND_K[ctl.phase];

  // Pick the byte to shift in: data, marker, zero or length byte
  assign len_bytes = bit_len;
  always_comb begin
    case (ctl.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_PAD:  byte_in = PAD_BYTE;
      SEL_LEN:  byte_in = len_bytes[3'd7 - fill[2:0]];
      default:  byte_in = 8'h00;
    endcase
  end

  // Digest word select
  always_comb begin
    case (ctl.word_sel)
      3'd0:    digest = hash[0];
      3'd1:    digest = hash[1];
      3'd2:    digest = hash[2];
      3'd3:    digest = hash[3];
      3'd4:    digest = hash[4];
      default: digest = 32'h0;
    endcase
  end

  assign stat.fill      = fill;
  assign stat.len_carry = &bit_len[63:3];

  // Control state: hash words, bit count, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      hash    <= H_INIT;
      bit_len <= '0;
      fill    <= '0;
    end else begin
      if (ctl.init_hash) begin
        hash    <= H_INIT;
        bit_len <= '0;
        fill    <= '0;
      end
      if (ctl.shift_en) begin
        fill <= fill + 6'd1;
      end
      if (ctl.count_len) begin
        bit_len <= bit_len + 64'd8;
      end
      if (ctl.clear_len) begin
        bit_len <= '0;
      end
      if (ctl.hash_add) begin
        hash[0] <= hash[0] + va;
        hash[1] <= hash[1] + vb;
        hash[2] <= hash[2] + vc;
        hash[3] <= hash[3] + vd;
        hash[4] <= hash[4] + ve;
      end
    end
  end

  // Payload: block shift line doubles as the rolling schedule window
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      sched <= {sched[503:0], byte_in};
    end else if (ctl.round_en) begin
      sched <= {sched[479:0], w_new};
    end
    if (ctl.load_vars) begin
      va <= hash[0];
      vb <= hash[1];
      vc <= hash[2];
      vd <= hash[3];
      ve <= hash[4];
    end else if (ctl.round_en) begin
      va <= t_sum;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

endmodule

@@ design/sha1bs_ctrl.sv @@
// Controller of the SHA-1 hasher: command decode, padding and round
// sequencing, digest readout. Uses sha1bs_pkg; drives sha1bs_dp.
module sha1bs_ctrl import sha1bs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  input  logic       out_free,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output dp_cmd_t    dpc,
  output res_t       res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_HADD  = 5'b00100,
    S_PAD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       computed, computed_next;
  logic       corrupted, corrupted_next;
  logic       fin, fin_next;
  logic       pad_first, pad_first_next;
  logic       len_phase, len_phase_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    widx_next      = widx;
    computed_next  = computed;
    corrupted_next = corrupted;
    fin_next       = fin;
    pad_first_next = pad_first;
    len_phase_next = len_phase;
    dpc            = '0;
    dpc.word_sel   = widx;
    res            = '0;

    // Round group from round counter
    if (rnd < 7'd20) begin
      dpc.phase = PH_CHOOSE;
    end else if (rnd < 7'd40) begin
      dpc.phase = PH_PAR_LO;
    end else if (rnd < 7'd60) begin
      dpc.phase = PH_MAJ;
    end else begin
      dpc.phase = PH_PAR_HI;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_START: begin
              dpc.init_hash  = 1'b1;
              computed_next  = 1'b0;
              corrupted_next = 1'b0;
              res.load       = 1'b1;
              res.status     = ST_OK;
              res.last       = 1'b1;
            end
            CMD_ABSORB: begin
              res.load = 1'b1;
              res.last = 1'b1;
              if (computed || corrupted) begin
                // Drop the byte and flag the message
                corrupted_next = 1'b1;
                res.status     = ST_ERROR;
              end else begin
                res.status    = ST_OK;
                dpc.shift_en  = 1'b1;
                dpc.byte_sel  = SEL_DATA;
                dpc.count_len = 1'b1;
                if (stat.len_carry) begin
                  corrupted_next = 1'b1;
                end
                if (stat.fill == FILL_LAST) begin
                  dpc.load_vars = 1'b1;
                  rnd_next      = '0;
                  state_next    = S_ROUND;
                end
              end
            end
            CMD_FINISH: begin
              if (corrupted) begin
                res.load   = 1'b1;
                res.status = ST_ERROR;
                res.last   = 1'b1;
              end else if (computed) begin
                widx_next  = '0;
                state_next = S_EMIT;
              end else begin
                fin_next       = 1'b1;
                pad_first_next = 1'b1;
                len_phase_next = 1'b0;
                state_next     = S_PAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        // Shift one padding byte per cycle
        dpc.shift_en   = 1'b1;
        pad_first_next = 1'b0;
        if (pad_first) begin
          dpc.byte_sel = SEL_PAD;
        end else if (len_phase || stat.fill == FILL_LEN) begin
          dpc.byte_sel   = SEL_LEN;
          len_phase_next = 1'b1;
        end else begin
          dpc.byte_sel = SEL_ZERO;
        end
        if (stat.fill == FILL_LAST) begin
          dpc.load_vars = 1'b1;
          rnd_next      = '0;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        dpc.round_en = 1'b1;
        rnd_next     = rnd + 7'd1;
        if (rnd == ROUND_LAST) begin
          state_next = S_HADD;
        end
      end
      S_HADD: begin
        dpc.hash_add = 1'b1;
        if (fin && len_phase) begin
          // Final block done: freeze digest and read it out
          dpc.clear_len  = 1'b1;
          computed_next  = 1'b1;
          fin_next       = 1'b0;
          len_phase_next = 1'b0;
          widx_next      = '0;
          state_next     = S_EMIT;
        end else if (fin) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res.load       = 1'b1;
          res.status     = ST_OK;
          res.use_digest = 1'b1;
          res.index      = widx;
          res.last       = (widx == WORD_LAST);
          widx_next      = widx + 3'd1;
          if (widx == WORD_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rnd       <= '0;
      widx      <= '0;
      computed  <= 1'b0;
      corrupted <= 1'b0;
      fin       <= 1'b0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      widx      <= widx_next;
      computed  <= computed_next;
      corrupted <= corrupted_next;
      fin       <= fin_next;
      pad_first <= pad_first_next;
      len_phase <= len_phase_next;
    end
  end

endmodule

@@ design/sha1_byte_stream_hasher.sv @@
// Byte-serial SHA-1 hasher. A data byte is one transfer; the byte that fills a
// 64-byte block makes it busy for 80 rounds, one per cycle, and the hash update.
// A first finish shifts 64 - fill or 128 - fill padding bytes at one per cycle,
// with rounds and update per block, then gives five results, one a cycle while
// the output register is free. Results sit in it; input waits until it is free.
// Reset (rst, synchronous) loads the initial hash words, clears counts and flags.
module sha1_byte_stream_hasher import sha1bs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        is_last
);

  dp_cmd_t     dpc;
  dp_stat_t    stat;
  res_t        res;
  logic [31:0] digest;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  sha1bs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .dpc      (dpc),
    .res      (res)
  );

  sha1bs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dpc),
    .data_byte (data_byte),
    .stat      (stat),
    .digest    (digest)
  );

  // Output register: load a result, hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status      <= res.status;
      digest_word <= res.use_digest ? digest : 32'h0;
      word_index  <= res.index;
      is_last     <= res.last;
    end
  end

endmodule

@@ sim/sha1_byte_stream_hasher_tb.sv @@
// Self-checking testbench for the byte-serial SHA-1 hasher: random message streams,
// a bit-accurate SHA-1 predictor and a scoreboard of digest words.
// Depends on design/sha1bs_pkg.sv and design/sha1_byte_stream_hasher.sv.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb import sha1bs_pkg::*; ();

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_CYCLES = 400;
  localparam int         HOLD_CYCLES = 300;
  localparam int         RANDOM_ITEMS = 350;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] payload;
  } hash_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_START;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        is_last;

  sha1_byte_stream_hasher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .digest_word(digest_word),
    .word_index(word_index),
    .is_last(is_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted hasher state
  logic [31:0] h_state [5];
  logic [63:0] msg_bits;
  logic [6:0]  fill_count;
  logic [7:0]  blk [64];
  logic        digest_done;
  logic        hasher_bad;

  hash_req_t    cmd_feed [$];
  digest_beat_t beats_due [$];
  hash_req_t    next_req;
  int           stim_total = 0;
  int           items_accepted = 0;
  int           error_count = 0;
  int           cycles = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         in_fired = 1'b0;
  logic         calm;

  // No idling on either side over this window of transfers
  assign calm = (items_accepted >= 150) && (items_accepted < 230);

  function automatic void restart_message();
    h_state[0] = 32'h67452301;
    h_state[1] = 32'hEFCDAB89;
    h_state[2] = 32'h98BADCFE;
    h_state[3] = 32'h10325476;
    h_state[4] = 32'hC3D2E1F0;
    msg_bits = '0;
    fill_count = '0;
    digest_done = 1'b0;
    hasher_bad = 1'b0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the hash words
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    int s;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    a = h_state[0];
    b = h_state[1];
    c = h_state[2];
    d = h_state[3];
    e = h_state[4];
    for (int t = 0; t < 80; t++) begin
      s = t % 16;
      if (t >= 16) begin
        tmp = w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s];
        w[s] = {tmp[30:0], tmp[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      tmp = {a[26:0], a[31:27]} + f + e + w[s] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    h_state[0] += a;
    h_state[1] += b;
    h_state[2] += c;
    h_state[3] += d;
    h_state[4] += e;
    fill_count = '0;
  endfunction

  // Append the pad marker, zeros and the big-endian bit length
  function automatic void pad_and_close();
    int pos;
    pos = fill_count[5:0];
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++)
      blk[56+i] = msg_bits[63-8*i -: 8];
    compress_block();
  endfunction

  function automatic void push_beat(logic st, logic [31:0] word, logic [2:0] idx,
                                    logic last);
    digest_beat_t beat;
    beat.status = st;
    beat.word = word;
    beat.index = idx;
    beat.last = last;
    beats_due.push_back(beat);
  endfunction

  // Update the predicted state for one accepted command, queue its results
  function automatic void sha1_predict(logic [1:0] op, logic [7:0] payload);
    case (op)
      CMD_START: begin
        restart_message();
        push_beat(ST_OK, '0, '0, 1'b1);
      end
      CMD_ABSORB: begin
        if (digest_done) begin
          hasher_bad = 1'b1;
          push_beat(ST_ERROR, '0, '0, 1'b1);
        end else if (hasher_bad) begin
          push_beat(ST_ERROR, '0, '0, 1'b1);
        end else begin
          blk[fill_count[5:0]] = payload;
          fill_count = fill_count + 7'd1;
          msg_bits = msg_bits + 64'd8;
          if (msg_bits == '0)
            hasher_bad = 1'b1;
          if (fill_count >= 7'd64)
            compress_block();
          push_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      CMD_FINISH: begin
        if (hasher_bad) begin
          push_beat(ST_ERROR, '0, '0, 1'b1);
        end else begin
          if (!digest_done) begin
            pad_and_close();
            for (int i = 0; i < 64; i++)
              blk[i] = 8'h00;
            msg_bits = '0;
            digest_done = 1'b1;
          end
          for (int i = 0; i < 5; i++)
            push_beat(ST_OK, h_state[i], 3'(i), i == 4);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_item(logic [1:0] op, logic [7:0] payload);
    hash_req_t req;
    req.op = op;
    req.payload = payload;
    cmd_feed.push_back(req);
    stim_total++;
  endfunction

  // Directed opening, then random messages; returns nothing, fills cmd_feed
  task automatic build_stimulus();
    int counted;
    int len;
    int pick;
    // Finish straight out of reset, repeat it, then corrupt and recover
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_FINISH, 8'hFF);
    push_item(CMD_ABSORB, 8'h00);
    push_item(CMD_ABSORB, 8'hFF);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_UNUSED, 8'hFF);
    push_item(CMD_START, 8'hFF);
    push_item(CMD_ABSORB, 8'h61);
    push_item(CMD_ABSORB, 8'h62);
    push_item(CMD_ABSORB, 8'h63);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_START, 8'h00);
    push_item(CMD_ABSORB, 8'hFF);
    push_item(CMD_ABSORB, 8'h00);
    push_item(CMD_UNUSED, 8'h00);
    push_item(CMD_ABSORB, 8'h80);
    push_item(CMD_FINISH, 8'hFF);
    push_item(CMD_START, 8'h00);
    push_item(CMD_START, 8'h00);
    push_item(CMD_FINISH, 8'h00);
    push_item(CMD_ABSORB, 8'h5A);
    push_item(CMD_START, 8'h00);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // Mostly well-formed messages; sometimes carry on from the old state
      if ($urandom_range(0, 99) < 90) begin
        push_item(CMD_START, 8'($urandom));
        counted++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, 12);
      end else if (pick < 85) begin
        len = $urandom_range(13, 70);
      end else begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          4: len = 119;
          5: len = 120;
          6: len = 127;
          default: len = 128;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 4)
          push_item(CMD_UNUSED, 8'($urandom));
        push_item(CMD_ABSORB, 8'($urandom));
        counted++;
      end
      if ($urandom_range(0, 99) < 90) begin
        push_item(CMD_FINISH, 8'($urandom));
        counted++;
        if ($urandom_range(0, 99) < 25) begin
          push_item(CMD_FINISH, 8'($urandom));
          counted++;
        end
        if ($urandom_range(0, 99) < 10) begin
          push_item(CMD_ABSORB, 8'($urandom));
          counted++;
          if ($urandom_range(0, 1) == 1) begin
            push_item(CMD_FINISH, 8'($urandom));
            counted++;
          end
        end
      end
    end
  endtask

  // Record input transfers and predict their results
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sha1_predict(cmd, data_byte);
      items_accepted <= items_accepted + 1;
      in_fired <= 1'b1;
    end else begin
      in_fired <= 1'b0;
    end
  end

  // Offer the next pending command, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (cmd_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
        next_req = cmd_feed.pop_front();
        in_valid <= 1'b1;
        cmd <= next_req.op;
        data_byte <= next_req.payload;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive the receiver: one long hold-off, random stalls otherwise
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void next_beat_check(digest_beat_t want);
    check_field("status", 32'(want.status), 32'(status));
    check_field("digest_word", want.word, digest_word);
    check_field("word_index", 32'(want.index), 32'(word_index));
    check_field("is_last", 32'(want.last), 32'(is_last));
  endfunction

  // Compare each output transfer with the oldest predicted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("result with none pending: status %0d word %0h index %0d last %0d",
               status, digest_word, word_index, is_last);
        error_count++;
      end else begin
        next_beat_check(beats_due.pop_front());
      end
    end
  end

  // Stop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sha1_byte_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    restart_message();
    build_stimulus();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Wait for every command to transfer and every result to drain
    while (items_accepted != stim_total || beats_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("sha1_byte_stream_hasher: match");
    else
      $display("sha1_byte_stream_hasher: mismatch");
    $finish;
  end

endmodule
